[rtl/packed_pixel_depth_expander_assert.svh]
`ifndef PACKED_PIXEL_DEPTH_EXPANDER_ASSERT_SVH
`define PACKED_PIXEL_DEPTH_EXPANDER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PPDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PPDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ppde_pkg.sv]
package ppde_pkg;

  localparam int unsigned PixelsPerWord = 8;
  localparam int unsigned NibbleBits    = 4;
  localparam int unsigned WordBits      = PixelsPerWord * NibbleBits;
  localparam int unsigned AccBits       = 24;
  localparam int unsigned PaletteBits   = 64;
  localparam int unsigned QueueDepth    = 2;

  // Configuration register indexes
  localparam logic [1:0] CFG_BPP     = 2'd0;
  localparam logic [1:0] CFG_PALETTE = 2'd1;
  localparam logic [1:0] CFG_REVERSE = 2'd2;

  localparam logic [2:0] BPP_RESET = 3'd4;

  // One gathered group on its way from the front to the back
  typedef struct packed {
    logic [WordBits-1:0] data;
    logic                last;
  } group_t;

  // Queue occupancy seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/packed_pixel_depth_expander.sv]
// Packed pixel depth expander.
// Input stream (s_axis_*): one packed source byte per transfer, tlast on the
// final byte of a buffer. Output stream (m_axis_*): one 32-bit word of eight
// 4-bit palette colors per completed group of bits_per_pixel bytes, or per
// buffer end, with tlast set on the word that the buffer end flushed.
// Configuration port (cfg_*): index 0 bits_per_pixel, 1 palette (16 nibbles),
// 2 reverse_order; always ready, write only while the stream is idle.
// Throughput: one byte per cycle sustained while s_axis_tready is high, one
// word per cycle at most. A completed group is written into the two-entry
// queue with the transfer of the byte that completes it, and moves on to the
// output register that drives m_axis once that register is empty or being
// drained. With an invalid depth (0, 5..7) bytes are taken and dropped.
// Reset: depth 4, palette all zero, ascending order, no bytes held, queue
// and output register empty.
// A stalled receiver holds the output word; the queue absorbs two more
// groups, after which s_axis_tready falls until the output drains.
module packed_pixel_depth_expander import ppde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // source bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] src_byte
  input  logic        s_axis_tlast,   // last_byte
  // expanded words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] row_word
  output logic        m_axis_tlast    // last_row
);

`include "packed_pixel_depth_expander_assert.svh"

  logic [2:0]             bpp_q;
  logic [PaletteBits-1:0] palette_q;
  logic                   reverse_q;
  logic                   push;
  logic                   pop;
  group_t                 push_group;
  group_t                 pop_group;
  q_status_t              q_status;

  // Take configuration writes; unknown indexes are ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q     <= BPP_RESET;
      palette_q <= '0;
      reverse_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BPP:     bpp_q     <= cfg_data_i[2:0];
        CFG_PALETTE: palette_q <= cfg_data_i;
        CFG_REVERSE: reverse_q <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  ppde_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bpp_i        (bpp_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .src_byte_i   (s_axis_tdata),
    .last_byte_i  (s_axis_tlast),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_group_o (push_group)
  );

  ppde_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (push_group),
    .pop_i        (pop),
    .pop_group_o  (pop_group),
    .status_o     (q_status)
  );

  ppde_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bpp_i       (bpp_q),
    .palette_i   (palette_q),
    .reverse_i   (reverse_q),
    .q_status_i  (q_status),
    .group_i     (pop_group),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .row_word_o  (m_axis_tdata),
    .last_row_o  (m_axis_tlast)
  );

  `PPDE_ASSERT_NOW(a_no_overflow, push, !q_status.full, "push into full queue")
  `PPDE_ASSERT_NOW(a_no_underflow, pop, !q_status.empty, "pop from empty queue")
  `PPDE_ASSERT_NEXT(a_output_refill, !q_status.empty && !m_axis_tvalid, m_axis_tvalid,
                    "queued group not moved to output")
  `PPDE_ASSERT_NOW(a_drop_bad_depth, (bpp_q == 3'd0) || (bpp_q > 3'd4), !push,
                   "group pushed with invalid depth")

endmodule

[rtl/ppde_front.sv]
module ppde_front import ppde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  bpp_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  src_byte_i,
  input  logic        last_byte_i,
  input  q_status_t   q_status_i,
  output logic        push_o,
  output group_t      push_group_o
);

  logic [AccBits-1:0]  acc_q, acc_d;
  logic [1:0]          cnt_q, cnt_d;
  logic [WordBits-1:0] merged;
  logic                bpp_ok;
  logic                group_done;
  logic                accept;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign bpp_ok     = (bpp_i != 3'd0) && (bpp_i <= 3'd4);
  assign group_done = (({1'b0, cnt_q} + 3'd1) >= bpp_i) || last_byte_i;

  // Place the new byte above the bytes already held
  always_comb begin
    merged = {8'h00, acc_q};
    case (cnt_q)
      2'd0:    merged[7:0]   = src_byte_i;
      2'd1:    merged[15:8]  = src_byte_i;
      2'd2:    merged[23:16] = src_byte_i;
      default: merged[31:24] = src_byte_i;
    endcase
  end

  assign push_o            = accept && bpp_ok && group_done;
  assign push_group_o.data = merged;
  assign push_group_o.last = last_byte_i;

  // Advance or clear the accumulator; drop bytes while the depth is invalid
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (accept && bpp_ok) begin
      if (group_done) begin
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = merged[AccBits-1:0];
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/ppde_queue.sv]
module ppde_queue import ppde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  group_t    push_group_i,
  input  logic      pop_i,
  output group_t    pop_group_o,
  output q_status_t status_o
);

  localparam int unsigned PtrBits = $clog2(QueueDepth);
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  group_t             slots_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;

  assign status_o.full  = (count_q == CntBits'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign pop_group_o    = slots_q[rd_ptr_q];

  // Hold entries; write at the tail
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_group_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[rtl/ppde_back.sv]
module ppde_back import ppde_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [2:0]             bpp_i,
  input  logic [PaletteBits-1:0] palette_i,
  input  logic                   reverse_i,
  input  q_status_t              q_status_i,
  input  group_t                 group_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [WordBits-1:0]    row_word_o,
  output logic                   last_row_o
);

  logic                valid_q;
  logic [WordBits-1:0] row_q, row_d;
  logic                last_q;

  // Look up each pixel in the palette and place its color
  always_comb begin
    logic [3:0] idx;
    logic [2:0] pos;
    row_d = '0;
    for (int j = 0; j < PixelsPerWord; j++) begin
      case (bpp_i)
        3'd1:    idx = {3'b000, group_i.data[j]};
        3'd2:    idx = {2'b00, group_i.data[2*j +: 2]};
        3'd3:    idx = {1'b0, group_i.data[3*j +: 3]};
        default: idx = group_i.data[4*j +: 4];
      endcase
      pos = reverse_i ? 3'(PixelsPerWord - 1 - j) : 3'(j);
      row_d[NibbleBits*pos +: NibbleBits] = palette_i[NibbleBits*idx +: NibbleBits];
    end
  end

  // Refill the output register when it is empty or being drained
  assign pop_o       = !q_status_i.empty && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign row_word_o  = row_q;
  assign last_row_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      row_q  <= row_d;
      last_q <= group_i.last;
    end
  end

endmodule

[tb/tb_packed_pixel_depth_expander.sv]
module tb_packed_pixel_depth_expander;
  import ppde_pkg::*;

  localparam logic [1:0]  CFG_SPARE      = 2'd3;   // index with no register behind it
  localparam logic [63:0] PAL_IDENTITY   = 64'hFEDCBA9876543210;
  localparam logic [63:0] PAL_ODD_3BPP   = 64'h76543210FEDCBA90;
  localparam logic [63:0] PAL_ALL_ONES   = 64'hFFFFFFFFFFFFFFFF;
  localparam int          RANDOM_BYTES   = 600;
  localparam int          QUIET_BYTES    = 100;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          TAIL_CYCLES    = 8;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } row_t;

  // Predicts the color words from accepted source bytes and checks them in order
  class color_row_tracker;
    logic [2:0]  depth;
    logic [63:0] palette;
    logic        reversed;
    logic [23:0] held_bytes;
    logic [1:0]  held_count;
    row_t        rows_due[$];
    int          bytes_used;
    int          rows_checked;
    int          flushed;
    int          errors;

    function new();
      depth        = BPP_RESET;
      palette      = '0;
      reversed     = 1'b0;
      held_bytes   = '0;
      held_count   = '0;
      bytes_used   = 0;
      rows_checked = 0;
      flushed      = 0;
      errors       = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        CFG_BPP:     depth    = val[2:0];
        CFG_PALETTE: palette  = val;
        CFG_REVERSE: reversed = val[0];
        default: ;
      endcase
    endfunction

    // Gather one byte, dropped under an invalid depth; emit a word once the group is complete or the buffer ends
    function void take_byte(logic [7:0] b, logic fin);
      logic [31:0] group;
      logic [31:0] word;
      logic [3:0]  idx;
      int          p;
      if (depth == 3'd0 || depth > 3'd4) return;
      bytes_used++;
      group = {8'h00, held_bytes} | ({24'h000000, b} << (8 * held_count));
      if (int'(held_count) + 1 >= int'(depth) || fin) begin
        word = '0;
        for (int j = 0; j < 8; j++) begin
          idx = 4'((group >> (depth * j)) & ((32'd1 << depth) - 32'd1));
          p = reversed ? 7 - j : j;
          word[4*p +: 4] = palette[4*idx +: 4];
        end
        rows_due.push_back('{word: word, last: fin});
        if (fin) flushed++;
        held_bytes = '0;
        held_count = '0;
      end else begin
        held_bytes = group[23:0];
        held_count = held_count + 2'd1;
      end
    endfunction

    function void check_row(logic [31:0] word, logic fin);
      row_t want;
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected row word %h last %b", $time, word, fin);
        errors++;
        return;
      end
      want = rows_due.pop_front();
      rows_checked++;
      if (word !== want.word) begin
        $display("%0t: row_word mismatch: expected %h, actual %h", $time, want.word, word);
        errors++;
      end
      if (fin !== want.last) begin
        $display("%0t: last_row mismatch: expected %b, actual %b", $time, want.last, fin);
        errors++;
      end
    endfunction

    function int pending();
      return rows_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  color_row_tracker tracker;
  int gap_odds;     // percent chance of a source gap before a byte
  int stall_odds;   // percent chance per cycle of starting a receiver stall
  int buf_left;
  int phases;
  int cfg_writes;

  packed_pixel_depth_expander u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: random stall bursts, none while stall_odds is zero
  initial begin
    int hold;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds) begin
        hold = $urandom_range(1, 15);
      end
      m_axis_tready <= (hold == 0);
    end
  end

  // Check each output transfer; sampled mid-cycle, the transfer lands on the next edge
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid && m_axis_tready) begin
      tracker.check_row(m_axis_tdata, m_axis_tlast);
    end
  end

  // Offer one byte, possibly after a gap; returns on the edge of its transfer with valid high
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int   gap;
    logic took;
    if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    tracker.take_byte(b, fin);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    logic took;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_valid_i <= 1'b0;
    tracker.set_reg(idx, val);
    cfg_writes++;
    @(posedge clk_i);
  endtask

  // Stop the source, drain every expected word, then let the pipeline go quiet
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic pick_odds();
    case ($urandom_range(0, 3))
      0: gap_odds = 0;
      1: gap_odds = 5;
      2: gap_odds = 15;
      default: gap_odds = 40;
    endcase
    case ($urandom_range(0, 3))
      0: stall_odds = 0;
      1: stall_odds = 2;
      2: stall_odds = 5;
      default: stall_odds = 12;
    endcase
  endtask

  task automatic random_settings();
    logic [63:0] val;
    logic [2:0]  pick;
    pick = 3'($urandom_range(1, 7));
    if (pick[0]) begin
      val = {$urandom, $urandom};
      val[2:0] = 3'($urandom_range(1, 4));
      write_reg(CFG_BPP, val);
    end
    if (pick[1]) begin
      case ($urandom_range(0, 5))
        0: val = '0;
        1: val = PAL_ALL_ONES;
        2: val = PAL_IDENTITY;
        3: val = PAL_ODD_3BPP;
        default: val = {$urandom, $urandom};
      endcase
      write_reg(CFG_PALETTE, val);
    end
    if (pick[2]) begin
      write_reg(CFG_REVERSE, {$urandom, $urandom});
    end
    if ($urandom_range(0, 9) == 0) begin
      write_reg(CFG_SPARE, {$urandom, $urandom});
    end
  endtask

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int          target;
    int          n;
    logic [63:0] val;
    logic        fin;
    tracker       = new();
    gap_odds      = 20;
    stall_odds    = 5;
    buf_left      = 0;
    phases        = 0;
    cfg_writes    = 0;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_BPP;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: depth 4, all-zero palette, early flush
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b1);

    // Depth 1, identity palette, ascending order
    wait_idle();
    write_reg(CFG_PALETTE, PAL_IDENTITY);
    write_reg(CFG_BPP, 64'd1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hA5, 1'b1);

    // Depth 2, reversed order, one full group and a padded one
    wait_idle();
    write_reg(CFG_BPP, 64'd2);
    write_reg(CFG_REVERSE, 64'd1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5A, 1'b1);

    // Fixed 3bpp variants: identity palette for even, nonzero plus 8 for odd
    wait_idle();
    write_reg(CFG_BPP, 64'd3);
    write_reg(CFG_REVERSE, 64'd0);
    push_byte(8'h88, 1'b0);
    push_byte(8'hC6, 1'b0);
    push_byte(8'hFA, 1'b0);
    wait_idle();
    write_reg(CFG_PALETTE, PAL_ODD_3BPP);
    push_byte(8'h88, 1'b0);
    push_byte(8'hC6, 1'b1);

    // Depth 4, all-ones palette, reversed order
    wait_idle();
    write_reg(CFG_BPP, 64'd4);
    write_reg(CFG_PALETTE, PAL_ALL_ONES);
    write_reg(CFG_REVERSE, 64'd1);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b0);

    // Out-of-range depths drop every byte, flush or not
    wait_idle();
    write_reg(CFG_PALETTE, PAL_IDENTITY);
    write_reg(CFG_REVERSE, 64'd0);
    for (int d = 0; d < 8; d++) begin
      if (d >= 1 && d <= 4) continue;
      wait_idle();
      write_reg(CFG_BPP, 64'(d));
      push_byte(8'hFF, 1'b1);
      push_byte(8'h3C, 1'b0);
    end

    // Depth lowered with three bytes held: the next byte completes the group
    wait_idle();
    write_reg(CFG_BPP, 64'd4);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    wait_idle();
    write_reg(CFG_BPP, 64'd1);
    push_byte(8'h44, 1'b0);

    // Held byte survives a dropped one under an invalid depth
    wait_idle();
    write_reg(CFG_BPP, 64'd4);
    write_reg(CFG_SPARE, 64'hFFFFFFFFFFFFFFFF);
    push_byte(8'h9A, 1'b0);
    wait_idle();
    write_reg(CFG_BPP, 64'd6);
    push_byte(8'hBC, 1'b0);
    wait_idle();
    write_reg(CFG_BPP, 64'd4);
    push_byte(8'hDE, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'h0F, 1'b0);

    // Random phases: buffers of random length, settings changed between phases
    target = tracker.bytes_used + RANDOM_BYTES;
    while (tracker.bytes_used < target) begin
      phases++;
      wait_idle();
      if (target - tracker.bytes_used <= QUIET_BYTES) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        pick_odds();
      end
      if ($urandom_range(0, 11) == 0) begin
        val = {$urandom, $urandom};
        case ($urandom_range(0, 3))
          0: val[2:0] = 3'd0;
          1: val[2:0] = 3'd5;
          2: val[2:0] = 3'd6;
          default: val[2:0] = 3'd7;
        endcase
        write_reg(CFG_BPP, val);
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'($urandom), 1'($urandom));
        wait_idle();
        write_reg(CFG_BPP, 64'($urandom_range(1, 4)));
      end
      random_settings();
      n = $urandom_range(10, 50);
      repeat (n) begin
        if (buf_left == 0) buf_left = $urandom_range(1, 12);
        fin = (buf_left == 1) || ($urandom_range(0, 19) == 0);
        buf_left = fin ? 0 : buf_left - 1;
        push_byte(8'($urandom), fin);
      end
    end

    // Drain and let the pipeline settle
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d row words never arrived", $time, tracker.pending());
      tracker.errors++;
    end

    $display("Covered %0d source bytes over %0d random phases and %0d register writes.",
             tracker.bytes_used, phases, cfg_writes);
    $display("Checked %0d row words, %0d of them flushed by a buffer end; %0d errors.",
             tracker.rows_checked, tracker.flushed, tracker.errors);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ppde_pkg.sv
rtl/ppde_front.sv
rtl/ppde_queue.sv
rtl/ppde_back.sv
rtl/packed_pixel_depth_expander.sv
tb/tb_packed_pixel_depth_expander.sv
